// ===== src/czw3_pkg.sv =====
// Shared types and constants for the three-way Czekanowski metric block.
// No dependencies; every other file in src imports this package.
package czw3_pkg;

   localparam int ACC_BITS                 = 32;
   localparam int DEFAULT_VALUE_BITS       = 16;
   localparam int DEFAULT_MAX_FIELDS       = 4096;
   localparam int DEFAULT_RESULT_FRAC_BITS = 16;
   localparam int QUEUE_DEPTH              = 2;

   // Finished sums of one vector triple, handed from the front to the divider
   typedef struct packed {
      logic [ACC_BITS-1:0] numerator;
      logic [ACC_BITS-1:0] denominator;
      logic                overflowed;
   } sums_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

// ===== src/czekanowski_three_way_metric.sv =====
// Three-way Czekanowski metric: field accumulation, triple queue and divider.
// Accepts one field per cycle; the front stalls only when the queue is full.
// The divider works on one triple at a time, one quotient bit per cycle, and skips
// the division when the denominator is zero; it pops the next triple only after
// the last result has entered the output register. The queue holds two triples.
// Synchronous active-high reset clears the sums, the queue and the handshakes.
module czekanowski_three_way_metric #(
   parameter int VALUE_BITS       = czw3_pkg::DEFAULT_VALUE_BITS,
   parameter int MAX_FIELDS       = czw3_pkg::DEFAULT_MAX_FIELDS,
   parameter int RESULT_FRAC_BITS = czw3_pkg::DEFAULT_RESULT_FRAC_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // value_a, value_b, value_c (VALUE_BITS each), zero padding
   input  logic [((3 * VALUE_BITS + 7) / 8) * 8 - 1:0]   req_tdata,
   // last_field
   input  logic                                          req_tlast,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // similarity (RESULT_FRAC_BITS+1), zero padding
   output logic [((RESULT_FRAC_BITS + 8) / 8) * 8 - 1:0] rsp_tdata,
   // zero_denominator, overflowed
   output logic [1:0]                                    rsp_tuser
);
   import czw3_pkg::*;

   localparam int RSP_DATA_BITS = ((RESULT_FRAC_BITS + 8) / 8) * 8;

   logic                      accept;
   logic                      push, pop, full, empty;
   sums_type                  push_data, pop_data;
   logic [RESULT_FRAC_BITS:0] similarity;
   logic                      zero_denominator, overflowed;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   czw3_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_FIELDS (MAX_FIELDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .value_a    (req_tdata[VALUE_BITS-1:0]),
      .value_b    (req_tdata[2*VALUE_BITS-1:VALUE_BITS]),
      .value_c    (req_tdata[3*VALUE_BITS-1:2*VALUE_BITS]),
      .last_field (req_tlast),
      .push       (push),
      .sums       (push_data)
   );

   czw3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   czw3_divider #(
      .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
   ) u_divider (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (empty),
      .queue_data       (pop_data),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .similarity       (similarity),
      .zero_denominator (zero_denominator),
      .overflowed       (overflowed)
   );

   assign rsp_tdata = RSP_DATA_BITS'(similarity);
   assign rsp_tuser = {overflowed, zero_denominator};

endmodule

// ===== src/czw3_front.sv =====
// Front end: per-field accumulation of the numerator and denominator sums.
// Depends on czw3_pkg; emits a sums_type transaction on the last field.
module czw3_front #(
   parameter int VALUE_BITS = czw3_pkg::DEFAULT_VALUE_BITS,
   parameter int MAX_FIELDS = czw3_pkg::DEFAULT_MAX_FIELDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [VALUE_BITS-1:0] value_a,
   input  logic [VALUE_BITS-1:0] value_b,
   input  logic [VALUE_BITS-1:0] value_c,
   input  logic                  last_field,
   output logic                  push,
   output czw3_pkg::sums_type    sums
);
   import czw3_pkg::*;

   localparam int CNT_BITS  = $clog2(MAX_FIELDS + 1);
   localparam int TERM_BITS = VALUE_BITS + 2;

   logic [ACC_BITS-1:0]  num_ff, num_in;
   logic [ACC_BITS-1:0]  den_ff, den_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;

   logic [VALUE_BITS-1:0] min_ab, min_ac, min_bc, min_abc;
   logic [TERM_BITS-1:0]  term, total;
   logic [ACC_BITS:0]     num_sum, den_sum;
   logic [ACC_BITS-1:0]   num_new, den_new;
   logic                  ovf_new, at_limit;

   always_comb begin
      min_ab  = (value_a < value_b) ? value_a : value_b;
      min_ac  = (value_a < value_c) ? value_a : value_c;
      min_bc  = (value_b < value_c) ? value_b : value_c;
      min_abc = (min_ab < value_c) ? min_ab : value_c;
      term    = TERM_BITS'(min_ab) + TERM_BITS'(min_ac) + TERM_BITS'(min_bc)
                - TERM_BITS'(min_abc);
      total   = TERM_BITS'(value_a) + TERM_BITS'(value_b) + TERM_BITS'(value_c);
      num_sum = {1'b0, num_ff} + (ACC_BITS + 1)'(term);
      den_sum = {1'b0, den_ff} + (ACC_BITS + 1)'(total);
      at_limit = (count_ff == CNT_BITS'(MAX_FIELDS));

      num_new = num_ff;
      den_new = den_ff;
      ovf_new = ovf_ff;
      if (at_limit) begin
         ovf_new = 1'b1;
      end else begin
         // saturate each sum at all ones
         num_new = num_sum[ACC_BITS] ? '1 : num_sum[ACC_BITS-1:0];
         den_new = den_sum[ACC_BITS] ? '1 : den_sum[ACC_BITS-1:0];
         if (num_sum[ACC_BITS] || den_sum[ACC_BITS]) begin
            ovf_new = 1'b1;
         end
      end

      push             = accept && last_field;
      sums.numerator   = num_new;
      sums.denominator = den_new;
      sums.overflowed  = ovf_new;

      num_in   = num_ff;
      den_in   = den_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (push) begin
         // triple done: start over
         num_in   = '0;
         den_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         num_in   = num_new;
         den_in   = den_new;
         ovf_in   = ovf_new;
         count_in = at_limit ? count_ff : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff   <= '0;
         den_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_FIELDS))
      else $error("field count passed its bound");
`endif

endmodule

// ===== src/czw3_queue.sv =====
// Short queue of finished triple sums between the front end and the divider.
// Depends on czw3_pkg for sums_type and QUEUE_DEPTH.
module czw3_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  czw3_pkg::sums_type push_data,
   input  logic               pop,
   output czw3_pkg::sums_type pop_data,
   output logic               full,
   output logic               empty
);
   import czw3_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   sums_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
      empty    = (count_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count passed its depth");
   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");
`endif

endmodule

// ===== src/czw3_divider.sv =====
// Back end: restoring divider for 3*num*2^F / (2*den), one quotient bit a cycle,
// with clamp, zero-denominator handling and an output register. Uses czw3_pkg.
module czw3_divider #(
   parameter int RESULT_FRAC_BITS = czw3_pkg::DEFAULT_RESULT_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        queue_empty,
   input  czw3_pkg::sums_type          queue_data,
   output logic                        pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [RESULT_FRAC_BITS:0]   similarity,
   output logic                        zero_denominator,
   output logic                        overflowed
);
   import czw3_pkg::*;

   localparam int QUOT_BITS = RESULT_FRAC_BITS + 1;
   localparam int ITER_BITS = $clog2(QUOT_BITS + 1);
   localparam logic [QUOT_BITS-1:0] ONE_FIXED = {1'b1, {RESULT_FRAC_BITS{1'b0}}};

   div_state_type          state_ff, state_in;
   logic [ACC_BITS:0]      rem_ff, rem_in;
   logic [ACC_BITS:0]      div_ff, div_in;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [ITER_BITS-1:0]   iter_ff, iter_in;
   logic                   bit_ff, bit_in;
   logic                   zero_ff, zero_in;
   logic                   ovf_ff, ovf_in;

   logic                   out_valid_ff, out_valid_in;
   logic [QUOT_BITS-1:0]   sim_out_ff, sim_out_in;
   logic                   zero_out_ff, zero_out_in;
   logic                   ovf_out_ff, ovf_out_in;

   logic [ACC_BITS+1:0]    triple;
   logic [ACC_BITS+1:0]    trial;
   logic [ACC_BITS+2:0]    diff;
   logic                   fits;
   logic                   load_out;

   always_comb begin
      triple = {queue_data.numerator, 1'b0} + (ACC_BITS + 2)'(queue_data.numerator);
      trial  = {rem_ff, bit_ff};
      diff   = {1'b0, trial} - {2'b00, div_ff};
      fits   = !diff[ACC_BITS+2];

      state_in = state_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quot_in  = quot_ff;
      iter_in  = iter_ff;
      bit_in   = bit_ff;
      zero_in  = zero_ff;
      ovf_in   = ovf_ff;
      pop      = 1'b0;
      load_out = 1'b0;

      case (state_ff)
         DIV_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               rem_in  = triple[ACC_BITS+1:1];
               bit_in  = triple[0];
               div_in  = {queue_data.denominator, 1'b0};
               quot_in = '0;
               iter_in = ITER_BITS'(QUOT_BITS);
               zero_in = (queue_data.denominator == '0);
               ovf_in  = queue_data.overflowed;
               state_in = (queue_data.denominator == '0) ? DIV_DONE : DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in  = fits ? diff[ACC_BITS:0] : trial[ACC_BITS:0];
            quot_in = {quot_ff[QUOT_BITS-2:0], fits};
            bit_in  = 1'b0;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == ITER_BITS'(1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            // wait for the output register to free up
            if (!out_valid_ff || out_ready) begin
               load_out = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase

      out_valid_in = load_out || (out_valid_ff && !out_ready);
      sim_out_in   = sim_out_ff;
      zero_out_in  = zero_out_ff;
      ovf_out_in   = ovf_out_ff;
      if (load_out) begin
         sim_out_in  = (quot_ff > ONE_FIXED) ? ONE_FIXED : quot_ff;
         zero_out_in = zero_ff;
         ovf_out_in  = ovf_ff;
      end

      out_valid        = out_valid_ff;
      similarity       = sim_out_ff;
      zero_denominator = zero_out_ff;
      overflowed       = ovf_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DIV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      iter_ff     <= iter_in;
      bit_ff      <= bit_in;
      zero_ff     <= zero_in;
      ovf_ff      <= ovf_in;
      sim_out_ff  <= sim_out_in;
      zero_out_ff <= zero_out_in;
      ovf_out_ff  <= ovf_out_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && zero_out_ff) |-> (sim_out_ff == '0))
      else $error("zero denominator with nonzero similarity");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (sim_out_ff <= ONE_FIXED))
      else $error("similarity above one");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN) |-> (iter_ff != '0))
      else $error("divider running with no iterations left");
`endif

endmodule
